/* rtl/ln_pkg.sv */
package ln_pkg;

  localparam int unsigned DATA_W    = 16;
  // Numerator width of the shared serial divider. It covers the squared sum
  // of the largest supported vector plus the rounding term.
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned SQ_W      = 40;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned V_W       = 32;
  localparam int unsigned Y_W       = 32;
  localparam int unsigned U3_W      = 18;
  localparam int unsigned MEAN_W    = 17;
  localparam int unsigned CEN_W     = 18;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Register index carried in paddr bit 2.
  localparam logic REG_EPSILON = 1'b0;
  localparam logic [DATA_W-1:0] EPSILON_RESET = 16'd1;

  localparam logic [U3_W-1:0] THREE_Q16 = 18'h30000;

  typedef enum logic [20:0] {
    S_LOAD = 21'h000001,
    S_MST  = 21'h000002,
    S_MDIV = 21'h000004,
    S_SR   = 21'h000008,
    S_SC   = 21'h000010,
    S_SM   = 21'h000020,
    S_SA   = 21'h000040,
    S_VST  = 21'h000080,
    S_VDIV = 21'h000100,
    S_NORM = 21'h000200,
    S_NT   = 21'h000400,
    S_NTS  = 21'h000800,
    S_NU   = 21'h001000,
    S_NUS  = 21'h002000,
    S_NY   = 21'h004000,
    S_NYS  = 21'h008000,
    S_OR   = 21'h010000,
    S_OC   = 21'h020000,
    S_OM1  = 21'h040000,
    S_OM2  = 21'h080000,
    S_OW   = 21'h100000
  } state_e;

endpackage

/* rtl/ln_in_if.sv */
interface ln_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ln_pkg::DATA_W-1:0]  sample;
  logic signed [ln_pkg::DATA_W-1:0]  gain;
  logic                              end_of_vector;

  modport source (output valid, sample, gain, end_of_vector, input ready);
  modport sink   (input valid, sample, gain, end_of_vector, output ready);
endinterface

/* rtl/ln_out_if.sv */
interface ln_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ln_pkg::DATA_W-1:0]  normalized;
  logic                              final_result;

  modport source (output valid, normalized, final_result, input ready);
  modport sink   (input valid, normalized, final_result, output ready);
endinterface

/* rtl/layer_norm_core.sv */
// Channel  | Dir | Handshake     | Word
// in_i     | in  | valid/ready   | sample, gain, end_of_vector
// out_o    | out | valid/ready   | normalized, final_result
// apb      | in  | psel/penable  | epsilon at byte address 0
//
// One word loads per cycle while the block is loading. A closing word starts the mean
// division, the squared-sum pass, the variance division, the leading-one scan, the Newton
// steps and the result pass, all built on the shared multiplier and the one-bit-a-cycle
// divider. Reset clears control and sets epsilon to one. A stalled output holds the result
// pass; no word is taken until the last result of a vector sits in the output register.
module layer_norm_core #(
  parameter int unsigned MAX_WIDTH    = 64,
  parameter int unsigned NEWTON_STEPS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ln_in_if.sink                        in_i,
  ln_out_if.source                     out_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [ln_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [ln_pkg::PDATA_W-1:0]   pwdata_i,
  output logic [ln_pkg::PDATA_W-1:0]   prdata_o,
  output logic                         pready_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SUM_W  = ln_pkg::DATA_W + ADDR_W;
  localparam int unsigned IT_W   = $clog2(NEWTON_STEPS);
  localparam int unsigned DW     = ln_pkg::DATA_W;

  // ---------------------------------------------------------------------
  // Configuration port. Only epsilon exists; a write to the upper address
  // is dropped.
  // ---------------------------------------------------------------------
  logic [DW-1:0] eps_q;
  logic          cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= ln_pkg::EPSILON_RESET;
    end else if (cfg_wr && (paddr_i[2] == ln_pkg::REG_EPSILON)) begin
      eps_q <= pwdata_i[DW-1:0];
    end
  end

  assign prdata_o = (paddr_i[2] == ln_pkg::REG_EPSILON) ?
                    {{(ln_pkg::PDATA_W-DW){1'b0}}, eps_q} : '0;

  // ---------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------
  ln_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [CNT_W-1:0]              n_q, n_d;
  logic [CNT_W-1:0]              k_q, k_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic                          sum_neg_q, sum_neg_d;
  logic signed [ln_pkg::MEAN_W-1:0] mean_q, mean_d;
  logic [ln_pkg::SQ_W-1:0]       sumsq_q, sumsq_d;
  logic [CNT_W-1:0]              rem_q, rem_d;
  logic [ln_pkg::DIV_W-1:0]      quo_q, quo_d;
  logic [ln_pkg::DIV_CNT_W-1:0]  dcnt_q, dcnt_d;
  logic [DW-1:0]                 cm_q, cm_d;
  logic [DW-1:0]                 gm_q, gm_d;
  logic                          neg_q, neg_d;
  logic [ln_pkg::V_W-1:0]        v_q, v_d;
  logic [ln_pkg::V_W-1:0]        vs_q, vs_d;
  logic [4:0]                    p_q, p_d;
  logic [ln_pkg::Y_W-1:0]        y_q, y_d;
  logic [ln_pkg::V_W-1:0]        t_q, t_d;
  logic [ln_pkg::U3_W-1:0]       u3_q, u3_d;
  logic [IT_W-1:0]               it_q, it_d;
  logic [ln_pkg::PROD_W-1:0]     prod_q;
  logic                          ovalid_q, ovalid_d;
  logic signed [DW-1:0]          onorm_q, onorm_d;
  logic                          ofinal_q, ofinal_d;

  // ---------------------------------------------------------------------
  // Element store: gain in the upper half, sample in the lower half. The
  // sequencer never reads while a vector is being loaded, so reads and
  // writes of the same entry cannot overlap.
  // ---------------------------------------------------------------------
  logic            in_acc;
  logic            store_we;
  logic [2*DW-1:0] rdata;

  assign in_i.ready = (state_q == ln_pkg::S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign store_we   = in_acc && (cnt_q < CNT_W'(MAX_WIDTH));

  ln_ram #(
    .WIDTH (2*DW),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i ({in_i.gain, in_i.sample}),
    .raddr_i (k_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------------
  // Shared multiplier with a registered product.
  // ---------------------------------------------------------------------
  logic [ln_pkg::MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ln_pkg::S_SM: begin
        mul_a = ln_pkg::MUL_W'(cm_q);
        mul_b = ln_pkg::MUL_W'(cm_q);
      end
      ln_pkg::S_OM1: begin
        mul_a = ln_pkg::MUL_W'(cm_q);
        mul_b = ln_pkg::MUL_W'(gm_q);
      end
      ln_pkg::S_OM2: begin
        mul_a = prod_q[ln_pkg::MUL_W-1:0];
        mul_b = y_q;
      end
      ln_pkg::S_NT: begin
        mul_a = v_q;
        mul_b = y_q;
      end
      ln_pkg::S_NU: begin
        mul_a = t_q;
        mul_b = y_q;
      end
      ln_pkg::S_NY: begin
        mul_a = y_q;
        mul_b = ln_pkg::MUL_W'(u3_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The product is held while a finished result waits for the output.
  always_ff @(posedge clk_i) begin
    if (state_q != ln_pkg::S_OW) begin
      prod_q <= ln_pkg::PROD_W'(mul_a) * ln_pkg::PROD_W'(mul_b);
    end
  end

  // ---------------------------------------------------------------------
  // Datapath helpers.
  // ---------------------------------------------------------------------
  // Restoring division step: one quotient bit a cycle, divisor is the count.
  logic [CNT_W:0] trial;
  logic           q_bit;
  assign trial = {rem_q, quo_q[ln_pkg::DIV_W-1]};
  assign q_bit = (trial >= {1'b0, n_q});

  logic [SUM_W-1:0] sum_mag;
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // Centered sample and gain from the store word.
  logic signed [DW-1:0]             rd_s, rd_g;
  logic signed [ln_pkg::CEN_W-1:0]  cen;
  assign rd_s = rdata[DW-1:0];
  assign rd_g = rdata[2*DW-1:DW];
  assign cen  = ln_pkg::CEN_W'(rd_s) - ln_pkg::CEN_W'(mean_q);

  logic [ln_pkg::DIV_W-1:0]  quo_fin;
  logic [ln_pkg::V_W-1:0]    var_sat;
  logic [ln_pkg::V_W:0]      v_sum;
  logic [ln_pkg::V_W-1:0]    v_fix;
  assign quo_fin = {quo_q[ln_pkg::DIV_W-2:0], q_bit};
  assign var_sat = (|quo_fin[ln_pkg::DIV_W-1:ln_pkg::V_W]) ? '1 : quo_fin[ln_pkg::V_W-1:0];
  assign v_sum   = {1'b0, var_sat} + (ln_pkg::V_W+1)'(eps_q);
  always_comb begin
    if (v_sum[ln_pkg::V_W]) begin
      v_fix = '1;
    end else if (v_sum[ln_pkg::V_W-1:0] == '0) begin
      // A zero sum is taken as one LSB.
      v_fix = ln_pkg::V_W'(1);
    end else begin
      v_fix = v_sum[ln_pkg::V_W-1:0];
    end
  end

  // Initial guess 2^(24 - ceil-ish(p/2)) from the leading-one position.
  logic [5:0] p_inc;
  logic [5:0] y_sh;
  assign p_inc = {1'b0, p_q} + 6'd1;
  assign y_sh  = 6'd24 - (p_inc >> 1);

  logic [47:0]              u_full;
  logic [ln_pkg::U3_W-1:0]  u_min;
  assign u_full = prod_q[63:16];
  assign u_min  = (u_full > 48'(ln_pkg::THREE_Q16)) ? ln_pkg::THREE_Q16 :
                  u_full[ln_pkg::U3_W-1:0];

  // Rounding of the 36-fraction-bit product down to 12 fraction bits.
  logic [ln_pkg::PROD_W-1:0] rnd;
  logic [39:0]               pm;
  logic signed [DW-1:0]      res;
  assign rnd = prod_q + (ln_pkg::PROD_W'(1) << 23);
  assign pm  = rnd[63:24];
  always_comb begin
    if (neg_q) begin
      res = (pm > 40'd32768) ? 16'sh8000 : DW'(-pm[DW-1:0]);
    end else begin
      res = (pm > 40'd32767) ? 16'sh7fff : pm[DW-1:0];
    end
  end

  logic out_free;
  assign out_free = !ovalid_q || out_o.ready;

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    k_d       = k_q;
    sum_d     = sum_q;
    sum_neg_d = sum_neg_q;
    mean_d    = mean_q;
    sumsq_d   = sumsq_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dcnt_d    = dcnt_q;
    cm_d      = cm_q;
    gm_d      = gm_q;
    neg_d     = neg_q;
    v_d       = v_q;
    vs_d      = vs_q;
    p_d       = p_q;
    y_d       = y_q;
    t_d       = t_q;
    u3_d      = u3_q;
    it_d      = it_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    onorm_d   = onorm_q;
    ofinal_d  = ofinal_q;

    unique case (state_q)
      ln_pkg::S_LOAD: begin
        if (in_acc) begin
          if (store_we) begin
            cnt_d = cnt_q + CNT_W'(1);
            sum_d = sum_q + SUM_W'(in_i.sample);
          end
          if (in_i.end_of_vector) begin
            n_d     = cnt_d;
            cnt_d   = '0;
            state_d = ln_pkg::S_MST;
          end
        end
      end
      ln_pkg::S_MST: begin
        quo_d     = ln_pkg::DIV_W'(sum_mag) + ln_pkg::DIV_W'(n_q >> 1);
        rem_d     = '0;
        dcnt_d    = '0;
        sum_neg_d = sum_q[SUM_W-1];
        sum_d     = '0;
        state_d   = ln_pkg::S_MDIV;
      end
      ln_pkg::S_MDIV: begin
        rem_d  = q_bit ? CNT_W'(trial - {1'b0, n_q}) : trial[CNT_W-1:0];
        quo_d  = quo_fin;
        dcnt_d = dcnt_q + ln_pkg::DIV_CNT_W'(1);
        if (dcnt_q == ln_pkg::DIV_CNT_W'(ln_pkg::DIV_W - 1)) begin
          mean_d  = sum_neg_q ? -quo_fin[ln_pkg::MEAN_W-1:0] : quo_fin[ln_pkg::MEAN_W-1:0];
          k_d     = '0;
          sumsq_d = '0;
          state_d = ln_pkg::S_SR;
        end
      end
      ln_pkg::S_SR: begin
        state_d = ln_pkg::S_SC;
      end
      ln_pkg::S_SC: begin
        cm_d    = cen[ln_pkg::CEN_W-1] ? DW'(-cen) : DW'(cen);
        state_d = ln_pkg::S_SM;
      end
      ln_pkg::S_SM: begin
        state_d = ln_pkg::S_SA;
      end
      ln_pkg::S_SA: begin
        sumsq_d = sumsq_q + ln_pkg::SQ_W'(prod_q[31:0]);
        if (k_q + CNT_W'(1) == n_q) begin
          state_d = ln_pkg::S_VST;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = ln_pkg::S_SR;
        end
      end
      ln_pkg::S_VST: begin
        quo_d   = ln_pkg::DIV_W'(sumsq_q) + ln_pkg::DIV_W'(n_q >> 1);
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = ln_pkg::S_VDIV;
      end
      ln_pkg::S_VDIV: begin
        rem_d  = q_bit ? CNT_W'(trial - {1'b0, n_q}) : trial[CNT_W-1:0];
        quo_d  = quo_fin;
        dcnt_d = dcnt_q + ln_pkg::DIV_CNT_W'(1);
        if (dcnt_q == ln_pkg::DIV_CNT_W'(ln_pkg::DIV_W - 1)) begin
          v_d     = v_fix;
          vs_d    = v_fix;
          p_d     = 5'd31;
          state_d = ln_pkg::S_NORM;
        end
      end
      ln_pkg::S_NORM: begin
        if ((p_q != 5'd0) && !vs_q[ln_pkg::V_W-1]) begin
          vs_d = vs_q << 1;
          p_d  = p_q - 5'd1;
        end else begin
          y_d     = ln_pkg::Y_W'(1) << y_sh;
          it_d    = '0;
          state_d = ln_pkg::S_NT;
        end
      end
      ln_pkg::S_NT: begin
        state_d = ln_pkg::S_NTS;
      end
      ln_pkg::S_NTS: begin
        t_d     = (|prod_q[63:48]) ? '1 : prod_q[47:16];
        state_d = ln_pkg::S_NU;
      end
      ln_pkg::S_NU: begin
        state_d = ln_pkg::S_NUS;
      end
      ln_pkg::S_NUS: begin
        u3_d    = ln_pkg::THREE_Q16 - u_min;
        state_d = ln_pkg::S_NY;
      end
      ln_pkg::S_NY: begin
        state_d = ln_pkg::S_NYS;
      end
      ln_pkg::S_NYS: begin
        y_d = prod_q[17 +: ln_pkg::Y_W];
        if (it_q == IT_W'(NEWTON_STEPS - 1)) begin
          k_d     = '0;
          state_d = ln_pkg::S_OR;
        end else begin
          it_d    = it_q + IT_W'(1);
          state_d = ln_pkg::S_NT;
        end
      end
      ln_pkg::S_OR: begin
        state_d = ln_pkg::S_OC;
      end
      ln_pkg::S_OC: begin
        cm_d    = cen[ln_pkg::CEN_W-1] ? DW'(-cen) : DW'(cen);
        gm_d    = rd_g[DW-1] ? DW'(-rd_g) : DW'(rd_g);
        neg_d   = cen[ln_pkg::CEN_W-1] ^ rd_g[DW-1];
        state_d = ln_pkg::S_OM1;
      end
      ln_pkg::S_OM1: begin
        state_d = ln_pkg::S_OM2;
      end
      ln_pkg::S_OM2: begin
        state_d = ln_pkg::S_OW;
      end
      ln_pkg::S_OW: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          onorm_d  = res;
          ofinal_d = (k_q + CNT_W'(1) == n_q);
          k_d      = k_q + CNT_W'(1);
          state_d  = (k_q + CNT_W'(1) == n_q) ? ln_pkg::S_LOAD : ln_pkg::S_OR;
        end
      end
      default: begin
        state_d = ln_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ln_pkg::S_LOAD;
      cnt_q    <= '0;
      sum_q    <= '0;
      k_q      <= '0;
      n_q      <= '0;
      it_q     <= '0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      k_q      <= k_d;
      n_q      <= n_d;
      it_q     <= it_d;
      dcnt_q   <= dcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_neg_q <= sum_neg_d;
    mean_q    <= mean_d;
    sumsq_q   <= sumsq_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    cm_q      <= cm_d;
    gm_q      <= gm_d;
    neg_q     <= neg_d;
    v_q       <= v_d;
    vs_q      <= vs_d;
    p_q       <= p_d;
    y_q       <= y_d;
    t_q       <= t_d;
    u3_q      <= u3_d;
    onorm_q   <= onorm_d;
    ofinal_q  <= ofinal_d;
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.normalized   = onorm_q;
  assign out_o.final_result = ofinal_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A new result only appears after the rounding step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == ln_pkg::S_OW))
    else $error("result appeared outside the rounding step");

  // Store reads stay inside the loaded part of the vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ln_pkg::S_SR || state_q == ln_pkg::S_OR) |-> (k_q < n_q))
    else $error("store read beyond the loaded elements");

  // The last result of a vector returns the block to loading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ln_pkg::S_OW && out_free && (k_q + CNT_W'(1) == n_q))
      |=> (state_q == ln_pkg::S_LOAD && cnt_q == '0 && ofinal_q))
    else $error("vector did not close after its last result");

  // The element count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (cnt_q <= CNT_W'(MAX_WIDTH)))
    else $error("element count exceeded the store depth");

endmodule

/* rtl/ln_ram.sv */
module ln_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
